### src/ladrc_pkg.sv
// ============================================================================
// ladrc_pkg
// Shared widths, constants, control-word layout and the microcode program
// of the linear ADRC speed loop.
// ============================================================================
package ladrc_pkg;

    localparam int STATE_BITS     = 48;
    localparam int GAIN_BITS      = 48;
    localparam int HALF_GAIN_BITS = GAIN_BITS / 2;
    localparam int WORD_BITS      = 32;
    localparam int FRAC_BITS      = 16;
    localparam int PP_BITS        = STATE_BITS + HALF_GAIN_BITS;
    localparam int PROD_BITS      = STATE_BITS + GAIN_BITS;
    localparam int DVD_BITS       = STATE_BITS + FRAC_BITS;
    localparam int REM_BITS       = WORD_BITS + 1;
    localparam int CFG_IDX_BITS   = 3;
    localparam int STEP_BITS      = 5;

    // multiply: capture, low partial, high partial, combine
    localparam int MUL_LAST = 3;
    // divide: load, one quotient bit per cycle, finish
    localparam int DIV_LAST = DVD_BITS + 1;
    localparam int CNT_BITS = $clog2(DIV_LAST + 1);

    localparam logic [CNT_BITS-1:0] CNT_LOAD     = CNT_BITS'(0);
    localparam logic [CNT_BITS-1:0] CNT_MUL_LO   = CNT_BITS'(1);
    localparam logic [CNT_BITS-1:0] CNT_MUL_HI   = CNT_BITS'(2);
    localparam logic [CNT_BITS-1:0] CNT_MUL_LAST = CNT_BITS'(MUL_LAST);
    localparam logic [CNT_BITS-1:0] CNT_DIV_LAST = CNT_BITS'(DIV_LAST);

    localparam logic [STATE_BITS-1:0] STATE_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
    localparam logic [STATE_BITS-1:0] STATE_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};

    // loop period 0.001 s in Q0.32, two pi in Q4.28
    localparam logic [GAIN_BITS-1:0] DT_Q32     = GAIN_BITS'(64'd4294967);
    localparam logic [GAIN_BITS-1:0] TWO_PI_Q28 = GAIN_BITS'(64'd1686629713);
    localparam int DT_SHIFT     = 32;
    localparam int TWO_PI_SHIFT = 28;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_BETA1 = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BETA2 = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BETA3 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_B0    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KP    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KD    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UPPER = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOWER = 3'd7;

    typedef logic [1:0] op_t;
    typedef logic [3:0] src_t;
    typedef logic [2:0] gain_t;
    typedef logic [1:0] cond_t;
    typedef logic [STEP_BITS-1:0] step_t;

    localparam op_t OP_WAIT = 2'd0;
    localparam op_t OP_ADD  = 2'd1;
    localparam op_t OP_MUL  = 2'd2;
    localparam op_t OP_DIV  = 2'd3;

    // operand / destination codes; the first eight are writable
    localparam src_t SRC_Z1   = 4'd0;
    localparam src_t SRC_Z2   = 4'd1;
    localparam src_t SRC_Z3   = 4'd2;
    localparam src_t SRC_E    = 4'd3;
    localparam src_t SRC_D1   = 4'd4;
    localparam src_t SRC_D2   = 4'd5;
    localparam src_t SRC_D3   = 4'd6;
    localparam src_t SRC_T    = 4'd7;
    localparam src_t SRC_FB   = 4'd8;
    localparam src_t SRC_REF  = 4'd9;
    localparam src_t SRC_LAST = 4'd10;
    localparam src_t SRC_ZERO = 4'd11;

    localparam gain_t GAIN_B1     = 3'd0;
    localparam gain_t GAIN_B2     = 3'd1;
    localparam gain_t GAIN_B3     = 3'd2;
    localparam gain_t GAIN_B0     = 3'd3;
    localparam gain_t GAIN_KP     = 3'd4;
    localparam gain_t GAIN_KD     = 3'd5;
    localparam gain_t GAIN_DT     = 3'd6;
    localparam gain_t GAIN_TWO_PI = 3'd7;

    localparam cond_t COND_NEVER   = 2'd0;
    localparam cond_t COND_ALWAYS  = 2'd1;
    localparam cond_t COND_NO_ITEM = 2'd2;

    localparam step_t STEP_IDLE = 5'd0;

    typedef struct packed {
        op_t   op;
        src_t  src_a;
        src_t  src_b;
        logic  neg_b;
        gain_t gain;
        src_t  dst;
        cond_t cond;
        step_t target;
    } ucode_t;

    function automatic ucode_t uword(input op_t op, input src_t a, input src_t b,
                                     input logic nb, input gain_t g, input src_t d,
                                     input cond_t c, input step_t t);
        ucode_t w;
        w.op     = op;
        w.src_a  = a;
        w.src_b  = b;
        w.neg_b  = nb;
        w.gain   = g;
        w.dst    = d;
        w.cond   = c;
        w.target = t;
        return w;
    endfunction

    function automatic ucode_t ucode_word(input step_t step);
        ucode_t w;
        unique case (step)
            5'd0:  w = uword(OP_WAIT, SRC_ZERO, SRC_ZERO, 1'b0, GAIN_B1, SRC_T,
                             COND_NO_ITEM, STEP_IDLE);
            // observer error and state derivatives
            5'd1:  w = uword(OP_ADD, SRC_Z1, SRC_FB, 1'b1, GAIN_B1, SRC_E,
                             COND_NEVER, STEP_IDLE);
            5'd2:  w = uword(OP_MUL, SRC_E, SRC_ZERO, 1'b0, GAIN_B1, SRC_T,
                             COND_NEVER, STEP_IDLE);
            5'd3:  w = uword(OP_ADD, SRC_Z2, SRC_T, 1'b1, GAIN_B1, SRC_D1,
                             COND_NEVER, STEP_IDLE);
            5'd4:  w = uword(OP_MUL, SRC_E, SRC_ZERO, 1'b0, GAIN_B2, SRC_T,
                             COND_NEVER, STEP_IDLE);
            5'd5:  w = uword(OP_ADD, SRC_Z3, SRC_T, 1'b1, GAIN_B1, SRC_D2,
                             COND_NEVER, STEP_IDLE);
            5'd6:  w = uword(OP_MUL, SRC_LAST, SRC_ZERO, 1'b0, GAIN_B0, SRC_T,
                             COND_NEVER, STEP_IDLE);
            5'd7:  w = uword(OP_ADD, SRC_D2, SRC_T, 1'b0, GAIN_B1, SRC_D2,
                             COND_NEVER, STEP_IDLE);
            5'd8:  w = uword(OP_MUL, SRC_E, SRC_ZERO, 1'b0, GAIN_B3, SRC_T,
                             COND_NEVER, STEP_IDLE);
            5'd9:  w = uword(OP_ADD, SRC_ZERO, SRC_T, 1'b1, GAIN_B1, SRC_D3,
                             COND_NEVER, STEP_IDLE);
            // integrate over one period
            5'd10: w = uword(OP_MUL, SRC_D1, SRC_ZERO, 1'b0, GAIN_DT, SRC_T,
                             COND_NEVER, STEP_IDLE);
            5'd11: w = uword(OP_ADD, SRC_Z1, SRC_T, 1'b0, GAIN_B1, SRC_Z1,
                             COND_NEVER, STEP_IDLE);
            5'd12: w = uword(OP_MUL, SRC_D2, SRC_ZERO, 1'b0, GAIN_DT, SRC_T,
                             COND_NEVER, STEP_IDLE);
            5'd13: w = uword(OP_ADD, SRC_Z2, SRC_T, 1'b0, GAIN_B1, SRC_Z2,
                             COND_NEVER, STEP_IDLE);
            5'd14: w = uword(OP_MUL, SRC_D3, SRC_ZERO, 1'b0, GAIN_DT, SRC_T,
                             COND_NEVER, STEP_IDLE);
            5'd15: w = uword(OP_ADD, SRC_Z3, SRC_T, 1'b0, GAIN_B1, SRC_Z3,
                             COND_NEVER, STEP_IDLE);
            // control law
            5'd16: w = uword(OP_MUL, SRC_REF, SRC_ZERO, 1'b0, GAIN_TWO_PI, SRC_T,
                             COND_NEVER, STEP_IDLE);
            5'd17: w = uword(OP_ADD, SRC_T, SRC_Z1, 1'b1, GAIN_B1, SRC_E,
                             COND_NEVER, STEP_IDLE);
            5'd18: w = uword(OP_MUL, SRC_E, SRC_ZERO, 1'b0, GAIN_KP, SRC_T,
                             COND_NEVER, STEP_IDLE);
            5'd19: w = uword(OP_MUL, SRC_Z2, SRC_ZERO, 1'b0, GAIN_KD, SRC_D1,
                             COND_NEVER, STEP_IDLE);
            5'd20: w = uword(OP_ADD, SRC_T, SRC_D1, 1'b1, GAIN_B1, SRC_E,
                             COND_NEVER, STEP_IDLE);
            5'd21: w = uword(OP_ADD, SRC_E, SRC_Z3, 1'b1, GAIN_B1, SRC_E,
                             COND_NEVER, STEP_IDLE);
            5'd22: w = uword(OP_DIV, SRC_E, SRC_ZERO, 1'b0, GAIN_B1, SRC_T,
                             COND_ALWAYS, STEP_IDLE);
            default: w = uword(OP_WAIT, SRC_ZERO, SRC_ZERO, 1'b0, GAIN_B1, SRC_T,
                               COND_ALWAYS, STEP_IDLE);
        endcase
        return w;
    endfunction

endpackage

### src/ladrc_stream_if.sv
// ============================================================================
// ladrc_stream_if
// Valid/ready channels of the ADRC speed loop: speed input and command output.
// ============================================================================
interface ladrc_in_if import ladrc_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] speed_ref_hz;
    logic signed [WORD_BITS-1:0] speed_feedback;

    modport source (output valid, output speed_ref_hz, output speed_feedback,
                    input ready);
    modport sink (input valid, input speed_ref_hz, input speed_feedback,
                  output ready);
endinterface

interface ladrc_out_if import ladrc_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] current_cmd;

    modport source (output valid, output current_cmd, input ready);
    modport sink (input valid, input current_cmd, output ready);
endinterface

### src/linear_adrc_speed_loop_core.sv
// ============================================================================
// linear_adrc_speed_loop_core
// Linear ADRC speed loop: third-order observer and control law run as a
// microcode program over a saturating adder, a shared multiplier and a
// bit-serial divider.
// ============================================================================
//  channel   | dir | handshake           | payload
//  ----------+-----+---------------------+----------------------------------
//  speed_in  | in  | valid/ready         | speed_ref_hz, speed_feedback
//  cmd_out   | out | valid/ready         | current_cmd
//  cfg       | in  | cfg_write strobe    | cfg_index, cfg_data
//
//  Each item runs 1 wait step, 11 add steps, 10 multiply steps (48x24
//  multiplier used twice per multiply) and the divide by b0, which
//  retires one quotient bit per cycle.
//  The result sits in an output register; the next item is accepted while
//  it waits, and the divide's last step holds until that register is free.
//  Reset clears the observer states and the last command and loads the
//  default gains and limits.
// ============================================================================
module linear_adrc_speed_loop_core import ladrc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [GAIN_BITS-1:0]    cfg_data,
    ladrc_in_if.sink                speed_in,
    ladrc_out_if.source             cmd_out
);

    // configuration
    logic [GAIN_BITS-1:0]        beta1_reg, beta2_reg, beta3_reg;
    logic [WORD_BITS-1:0]        b0_reg, kp_reg, kd_reg;
    logic signed [WORD_BITS-1:0] upper_reg, lower_reg;

    // datapath registers
    logic signed [STATE_BITS-1:0] z1_reg, z2_reg, z3_reg;
    logic signed [STATE_BITS-1:0] e_reg, d1_reg, d2_reg, d3_reg, t_reg;
    logic signed [WORD_BITS-1:0]  last_reg, ref_reg, fb_reg;

    // sequencer
    step_t                 step_reg, step_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    ucode_t                uc;

    // multiplier / divider
    logic [STATE_BITS-1:0] mag_reg;
    logic [GAIN_BITS-1:0]  gain_reg;
    logic                  sign_reg;
    logic [PP_BITS-1:0]    pp_lo_reg, pp_hi_reg;
    logic [DVD_BITS-1:0]   dvd_reg;
    logic [WORD_BITS-1:0]  rem_reg;

    // output slot
    logic                        out_valid_reg;
    logic signed [WORD_BITS-1:0] out_cmd_reg;

    logic signed [STATE_BITS-1:0] a_val, b_val, b_adj, add_res, mul_res, wr_val;
    logic [STATE_BITS-1:0]        a_mag;
    logic signed [STATE_BITS:0]   sum;
    logic [GAIN_BITS-1:0]         gain_val;
    logic [HALF_GAIN_BITS-1:0]    mul_b;
    logic [PP_BITS-1:0]           mul_p;
    logic [PROD_BITS-1:0]         prod, shifted;
    logic [WORD_BITS-1:0]         b0_eff;
    logic [REM_BITS-1:0]          rem_shift, rem_sub;
    logic                         q_bit;
    logic signed [DVD_BITS:0]     u_wide, upper_w, lower_w;
    logic signed [WORD_BITS-1:0]  u_clamped;
    logic                         in_acc, out_free, op_done, take_jump, wr_en;
    logic                         div_finish;

    assign uc = ucode_word(step_reg);

    assign in_acc         = speed_in.valid && speed_in.ready;
    assign speed_in.ready = (uc.op == OP_WAIT);
    assign out_free       = !out_valid_reg || cmd_out.ready;
    assign cmd_out.valid       = out_valid_reg;
    assign cmd_out.current_cmd = out_cmd_reg;

    // ---------------- operand selection ----------------
    always_comb
    begin
        case (uc.src_a)
            SRC_Z1:   a_val = z1_reg;
            SRC_Z2:   a_val = z2_reg;
            SRC_Z3:   a_val = z3_reg;
            SRC_E:    a_val = e_reg;
            SRC_D1:   a_val = d1_reg;
            SRC_D2:   a_val = d2_reg;
            SRC_D3:   a_val = d3_reg;
            SRC_T:    a_val = t_reg;
            SRC_FB:   a_val = STATE_BITS'(fb_reg);
            SRC_REF:  a_val = STATE_BITS'(ref_reg);
            SRC_LAST: a_val = STATE_BITS'(last_reg);
            default:  a_val = '0;
        endcase
        case (uc.src_b)
            SRC_Z1:   b_val = z1_reg;
            SRC_Z2:   b_val = z2_reg;
            SRC_Z3:   b_val = z3_reg;
            SRC_E:    b_val = e_reg;
            SRC_D1:   b_val = d1_reg;
            SRC_D2:   b_val = d2_reg;
            SRC_D3:   b_val = d3_reg;
            SRC_T:    b_val = t_reg;
            SRC_FB:   b_val = STATE_BITS'(fb_reg);
            SRC_REF:  b_val = STATE_BITS'(ref_reg);
            SRC_LAST: b_val = STATE_BITS'(last_reg);
            default:  b_val = '0;
        endcase
        case (uc.gain)
            GAIN_B1:     gain_val = beta1_reg;
            GAIN_B2:     gain_val = beta2_reg;
            GAIN_B3:     gain_val = beta3_reg;
            GAIN_B0:     gain_val = GAIN_BITS'(b0_reg);
            GAIN_KP:     gain_val = GAIN_BITS'(kp_reg);
            GAIN_KD:     gain_val = GAIN_BITS'(kd_reg);
            GAIN_DT:     gain_val = DT_Q32;
            GAIN_TWO_PI: gain_val = TWO_PI_Q28;
            default:     gain_val = '0;
        endcase
    end

    assign a_mag = a_val[STATE_BITS-1] ? STATE_BITS'(-a_val) : a_val;

    // ---------------- saturating adder ----------------
    // negation saturates on its own before the add
    always_comb
    begin
        if (!uc.neg_b)
            b_adj = b_val;
        else if (b_val == STATE_MIN)
            b_adj = STATE_MAX;
        else
            b_adj = -b_val;
        sum = {a_val[STATE_BITS-1], a_val} + {b_adj[STATE_BITS-1], b_adj};
        if (sum[STATE_BITS] != sum[STATE_BITS-1])
            add_res = sum[STATE_BITS] ? STATE_MIN : STATE_MAX;
        else
            add_res = sum[STATE_BITS-1:0];
    end

    // ---------------- multiplier ----------------
    assign mul_b = (cnt_reg == CNT_MUL_LO) ? gain_reg[HALF_GAIN_BITS-1:0]
                                           : gain_reg[GAIN_BITS-1:HALF_GAIN_BITS];
    assign mul_p = PP_BITS'(mag_reg) * PP_BITS'(mul_b);

    always_comb
    begin
        prod = {pp_hi_reg, {HALF_GAIN_BITS{1'b0}}} + PROD_BITS'(pp_lo_reg);
        case (uc.gain)
            GAIN_DT:     shifted = prod >> DT_SHIFT;
            GAIN_TWO_PI: shifted = prod >> TWO_PI_SHIFT;
            default:     shifted = prod >> FRAC_BITS;
        endcase
        // magnitude truncated toward zero, then saturated with its sign
        if (sign_reg)
            mul_res = (shifted > PROD_BITS'(STATE_MIN)) ? STATE_MIN
                                                       : -shifted[STATE_BITS-1:0];
        else
            mul_res = (shifted > PROD_BITS'(STATE_MAX)) ? STATE_MAX
                                                       : shifted[STATE_BITS-1:0];
    end

    // ---------------- divider and clamp ----------------
    assign b0_eff    = (b0_reg == '0) ? WORD_BITS'(1) : b0_reg;
    assign rem_shift = {rem_reg, dvd_reg[DVD_BITS-1]};
    assign q_bit     = (rem_shift >= {1'b0, b0_eff});
    assign rem_sub   = q_bit ? (rem_shift - {1'b0, b0_eff}) : rem_shift;

    always_comb
    begin
        u_wide  = sign_reg ? -$signed({1'b0, dvd_reg}) : $signed({1'b0, dvd_reg});
        upper_w = (DVD_BITS+1)'(upper_reg);
        lower_w = (DVD_BITS+1)'(lower_reg);
        if (u_wide > upper_w)
            u_clamped = upper_reg;
        else if (u_wide < lower_w)
            u_clamped = lower_reg;
        else
            u_clamped = u_wide[WORD_BITS-1:0];
    end

    // ---------------- sequencer ----------------
    assign div_finish = (uc.op == OP_DIV) && (cnt_reg == CNT_DIV_LAST) && out_free;

    always_comb
    begin
        unique case (uc.op)
            OP_WAIT: op_done = 1'b1;
            OP_ADD:  op_done = 1'b1;
            OP_MUL:  op_done = (cnt_reg == CNT_MUL_LAST);
            OP_DIV:  op_done = div_finish;
            default: op_done = 1'b1;
        endcase
        unique case (uc.cond)
            COND_ALWAYS:  take_jump = 1'b1;
            COND_NO_ITEM: take_jump = !in_acc;
            default:      take_jump = 1'b0;
        endcase
        if (!op_done)
            step_next = step_reg;
        else if (take_jump)
            step_next = uc.target;
        else
            step_next = step_reg + step_t'(1);
        if (op_done)
            cnt_next = CNT_LOAD;
        else if (cnt_reg == CNT_DIV_LAST)
            cnt_next = cnt_reg;
        else
            cnt_next = cnt_reg + CNT_BITS'(1);
        wr_en  = (uc.op == OP_ADD) || ((uc.op == OP_MUL) && (cnt_reg == CNT_MUL_LAST));
        wr_val = (uc.op == OP_ADD) ? add_res : mul_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
            cnt_reg  <= CNT_LOAD;
        end
        else
        begin
            step_reg <= step_next;
            cnt_reg  <= cnt_next;
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta1_reg <= GAIN_BITS'(64'd19660800);
            beta2_reg <= GAIN_BITS'(64'd1966080000);
            beta3_reg <= GAIN_BITS'(64'd65536000000);
            b0_reg    <= WORD_BITS'(13107200);
            kp_reg    <= WORD_BITS'(163840000);
            kd_reg    <= WORD_BITS'(6553600);
            upper_reg <= WORD_BITS'(327680);
            lower_reg <= -WORD_BITS'(327680);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_BETA1: beta1_reg <= cfg_data;
                CFG_BETA2: beta2_reg <= cfg_data;
                CFG_BETA3: beta3_reg <= cfg_data;
                CFG_B0:    b0_reg    <= cfg_data[WORD_BITS-1:0];
                CFG_KP:    kp_reg    <= cfg_data[WORD_BITS-1:0];
                CFG_KD:    kd_reg    <= cfg_data[WORD_BITS-1:0];
                CFG_UPPER: upper_reg <= cfg_data[WORD_BITS-1:0];
                CFG_LOWER: lower_reg <= cfg_data[WORD_BITS-1:0];
                default:   ;
            endcase
        end
    end

    // ---------------- observer state, last command, output slot ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z1_reg        <= '0;
            z2_reg        <= '0;
            z3_reg        <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                case (uc.dst)
                    SRC_Z1:  z1_reg <= wr_val;
                    SRC_Z2:  z2_reg <= wr_val;
                    SRC_Z3:  z3_reg <= wr_val;
                    default: ;
                endcase
            end
            if (div_finish)
            begin
                last_reg      <= u_clamped;
                out_valid_reg <= 1'b1;
            end
            else if (cmd_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ref_reg <= speed_in.speed_ref_hz;
            fb_reg  <= speed_in.speed_feedback;
        end
        if (div_finish)
            out_cmd_reg <= u_clamped;
        if (wr_en)
        begin
            case (uc.dst)
                SRC_E:   e_reg  <= wr_val;
                SRC_D1:  d1_reg <= wr_val;
                SRC_D2:  d2_reg <= wr_val;
                SRC_D3:  d3_reg <= wr_val;
                SRC_T:   t_reg  <= wr_val;
                default: ;
            endcase
        end
        if (uc.op == OP_MUL)
        begin
            if (cnt_reg == CNT_LOAD)
            begin
                mag_reg  <= a_mag;
                gain_reg <= gain_val;
                sign_reg <= a_val[STATE_BITS-1];
            end
            if (cnt_reg == CNT_MUL_LO)
                pp_lo_reg <= mul_p;
            if (cnt_reg == CNT_MUL_HI)
                pp_hi_reg <= mul_p;
        end
        if (uc.op == OP_DIV)
        begin
            if (cnt_reg == CNT_LOAD)
            begin
                dvd_reg  <= {a_mag, {FRAC_BITS{1'b0}}};
                rem_reg  <= '0;
                sign_reg <= a_val[STATE_BITS-1];
            end
            else if (cnt_reg != CNT_DIV_LAST)
            begin
                // quotient bits shift in as dividend bits shift out
                dvd_reg <= {dvd_reg[DVD_BITS-2:0], q_bit};
                rem_reg <= rem_sub[WORD_BITS-1:0];
            end
        end
    end

    // ---------------- assertions ----------------
    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !speed_in.ready)
        else $error("input accepted while program still running");

    a_result_from_divide: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cmd_out.valid) |-> $past(uc.op == OP_DIV && cnt_reg == CNT_DIV_LAST))
        else $error("result appeared outside the divide finish step");

    a_mul_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (uc.op == OP_MUL) |-> (cnt_reg <= CNT_MUL_LAST))
        else $error("multiply phase counter overran");

    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (uc.op == OP_WAIT || uc.op == OP_ADD) |-> (cnt_reg == CNT_LOAD))
        else $error("phase counter not cleared on single-cycle step");

endmodule

### tb/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the linear ADRC speed loop. A bit-accurate
// fixed-point copy of the observer and control law predicts each current
// command. Directed corners come first, then randomized phases with varied
// gain and limit settings, random idling on both channels and one long
// output hold-off.
// ============================================================================
module tb_top import ladrc_pkg::*; ();

    localparam longint SAT_HI      = (longint'(1) <<< (STATE_BITS - 1)) - 1;
    localparam longint SAT_LO      = -SAT_HI - 1;
    localparam longint SAT_SPAN    = SAT_HI + 1;
    localparam longint LOOP_DT     = 4294967;      // 0.001 in Q0.32
    localparam longint TWO_PI      = 1686629713;   // Q4.28
    localparam int     STALL_LIMIT = 8000;
    localparam int     LONG_HOLD   = 2000;
    localparam int     DRAIN_WAIT  = 150;

    class adrc_cmd_tracker;
        logic [47:0]        beta1, beta2, beta3;
        logic [31:0]        b0, kp, kd;
        longint             upper, lower;
        longint             z1, z2, z3, last_cmd;
        logic signed [31:0] expected_cmds[$];
        int                 errors;

        function new();
            beta1    = 48'd19660800;
            beta2    = 48'd1966080000;
            beta3    = 48'd65536000000;
            b0       = 32'd13107200;
            kp       = 32'd163840000;
            kd       = 32'd6553600;
            upper    = 327680;
            lower    = -327680;
            z1       = 0;
            z2       = 0;
            z3       = 0;
            last_cmd = 0;
            errors   = 0;
        endfunction

        static function longint clip(longint v);
            if (v > SAT_HI)
                return SAT_HI;
            if (v < SAT_LO)
                return SAT_LO;
            return v;
        endfunction

        static function longint sat_add(longint a, longint b);
            return clip(a + b);
        endfunction

        static function longint sat_neg(longint a);
            return clip(-a);
        endfunction

        // exact product, magnitude shifted down, saturated to state range
        static function longint scale_q(longint a, logic [63:0] g, int unsigned sh);
            logic [127:0] prod;
            longint       m;
            m    = (a < 0) ? -a : a;
            prod = 128'(m) * 128'(g);
            prod = prod >> sh;
            if (a < 0)
                return (prod > 128'(SAT_SPAN)) ? SAT_LO : -longint'(prod[63:0]);
            return (prod > 128'(SAT_HI)) ? SAT_HI : longint'(prod[63:0]);
        endfunction

        // zero b0 divides by the least step
        static function longint div_by_b0(longint num, logic [31:0] d);
            logic [127:0] q;
            logic [63:0]  m;
            logic [63:0]  dd;
            dd = (d == 32'd0) ? 64'd1 : {32'd0, d};
            m  = (num < 0) ? -num : num;
            q  = (128'(m) << 16) / 128'(dd);
            if (q > 128'(64'h7FFF_FFFF_FFFF_FFFF))
                q = 128'(64'h7FFF_FFFF_FFFF_FFFF);
            return (num < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [GAIN_BITS-1:0] v);
            logic signed [31:0] s;
            s = v[31:0];
            case (idx)
                CFG_BETA1: beta1 = v;
                CFG_BETA2: beta2 = v;
                CFG_BETA3: beta3 = v;
                CFG_B0:    b0    = v[31:0];
                CFG_KP:    kp    = v[31:0];
                CFG_KD:    kd    = v[31:0];
                CFG_UPPER: upper = s;
                CFG_LOWER: lower = s;
                default:   ;
            endcase
        endfunction

        function void take_sample(logic signed [31:0] ref_hz, logic signed [31:0] fb);
            longint r, f, e, d1, d2, d3, err, num, u;
            r  = ref_hz;
            f  = fb;
            e  = sat_add(z1, sat_neg(clip(f)));
            d1 = sat_add(z2, sat_neg(scale_q(e, beta1, 16)));
            d2 = sat_add(sat_add(z3, sat_neg(scale_q(e, beta2, 16))),
                         scale_q(last_cmd, b0, 16));
            d3 = sat_neg(scale_q(e, beta3, 16));
            z1 = sat_add(z1, scale_q(d1, LOOP_DT, 32));
            z2 = sat_add(z2, scale_q(d2, LOOP_DT, 32));
            z3 = sat_add(z3, scale_q(d3, LOOP_DT, 32));
            err = sat_add(scale_q(r, TWO_PI, 28), sat_neg(z1));
            num = sat_add(sat_add(scale_q(err, kp, 16), sat_neg(scale_q(z2, kd, 16))),
                          sat_neg(z3));
            u = div_by_b0(num, b0);
            // crossed limits: upper wins for values above it
            if (u > upper)
                u = upper;
            else if (u < lower)
                u = lower;
            last_cmd = u;
            expected_cmds.push_back(32'(u));
        endfunction

        function void check_cmd(logic signed [31:0] got);
            logic signed [31:0] want;
            if (expected_cmds.size() == 0)
            begin
                $error("current_cmd: unexpected item, expected none, actual %0d", got);
                errors++;
                return;
            end
            want = expected_cmds.pop_front();
            if (got !== want)
            begin
                $error("current_cmd: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_write;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [GAIN_BITS-1:0]    cfg_data;

    ladrc_in_if  speed_in();
    ladrc_out_if cmd_out();

    linear_adrc_speed_loop_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .speed_in  (speed_in),
        .cmd_out   (cmd_out)
    );

    adrc_cmd_tracker tracker;
    bit              quiet    = 1'b0;
    bit              hold_req = 1'b0;
    int              rx_hold  = 0;
    int              idle_cycles = 0;
    int              styles[12] = '{1, 1, 0, 2, 1, 3, 1, 2, 1, 3, 1, 0};

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int draw_tx_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    function automatic int draw_rx_stall();
        int r;
        r = $urandom_range(0, 999);
        if (r < 700)
            return 0;
        if (r < 930)
            return $urandom_range(1, 3);
        if (r < 990)
            return $urandom_range(4, 20);
        return $urandom_range(60, 300);
    endfunction

    function automatic logic [31:0] corner_word();
        case ($urandom_range(0, 4))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            3:       return 32'hFFFF_FFFF;
            default: return 32'h1;
        endcase
    endfunction

    function automatic logic [47:0] pick_extreme();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return '1;
            default: return {16'($urandom), $urandom};
        endcase
    endfunction

    // output side: ready drops for random stretches, or one long hold on request
    initial
    begin
        cmd_out.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                rx_hold  = LONG_HOLD;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                cmd_out.ready <= 1'b0;
            end
            else
            begin
                cmd_out.ready <= 1'b1;
                if (!quiet)
                    rx_hold = draw_rx_stall();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_out.valid && cmd_out.ready)
                tracker.check_cmd(cmd_out.current_cmd);
            if (speed_in.valid && speed_in.ready)
                tracker.take_sample(speed_in.speed_ref_hz, speed_in.speed_feedback);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (speed_in.valid && speed_in.ready) || (cmd_out.valid && cmd_out.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic put_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [GAIN_BITS-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        tracker.write_reg(idx, data);
    endtask

    task automatic program_regs(input logic [47:0] b1, input logic [47:0] b2,
                                input logic [47:0] b3, input logic [47:0] pg,
                                input logic [47:0] p, input logic [47:0] d,
                                input logic [47:0] hi, input logic [47:0] lo);
        put_reg(CFG_BETA1, b1);
        put_reg(CFG_BETA2, b2);
        put_reg(CFG_BETA3, b3);
        put_reg(CFG_B0, pg);
        put_reg(CFG_KP, p);
        put_reg(CFG_KD, d);
        put_reg(CFG_UPPER, hi);
        put_reg(CFG_LOWER, lo);
        cfg_write <= 1'b0;
    endtask

    task automatic program_style(input int style);
        logic [47:0] b1, b2, b3, pg, p, d, hi, lo;
        longint      w0, wc;
        int          lim;
        case (style)
            0:
            begin
                b1 = 48'd19660800;
                b2 = 48'd1966080000;
                b3 = 48'd65536000000;
                pg = 48'd13107200;
                p  = 48'd163840000;
                d  = 48'd6553600;
                hi = 48'd327680;
                lo = {16'd0, 32'hFFFB_0000};
            end
            1:
            begin
                // gains derived from observer and controller bandwidths
                w0  = $urandom_range(10, 1000);
                wc  = $urandom_range(5, 200);
                lim = $urandom_range(1, 50) << 16;
                b1  = 48'(3 * w0 * 65536);
                b2  = 48'(3 * w0 * w0 * 65536);
                b3  = 48'(w0 * w0 * w0 * 65536);
                pg  = 48'(longint'($urandom_range(1, 2000)) * 65536);
                p   = 48'(wc * wc * 65536);
                d   = 48'(2 * wc * 65536);
                hi  = {16'd0, 32'(lim)};
                lo  = {16'd0, 32'(-lim)};
                if ($urandom_range(0, 4) == 0)
                begin
                    hi = {16'd0, 32'(-lim)};
                    lo = {16'd0, 32'(lim)};
                end
            end
            2:
            begin
                b1 = {16'($urandom), $urandom};
                b2 = {16'($urandom), $urandom};
                b3 = {16'($urandom), $urandom};
                pg = {16'($urandom), $urandom};
                p  = {16'($urandom), $urandom};
                d  = {16'($urandom), $urandom};
                hi = {16'($urandom), $urandom};
                lo = {16'($urandom), $urandom};
            end
            default:
            begin
                b1 = pick_extreme();
                b2 = pick_extreme();
                b3 = pick_extreme();
                pg = pick_extreme();
                p  = pick_extreme();
                d  = pick_extreme();
                hi = {16'($urandom), corner_word()};
                lo = {16'($urandom), corner_word()};
            end
        endcase
        program_regs(b1, b2, b3, pg, p, d, hi, lo);
    endtask

    // valid stays high between back-to-back items; it drops only for a gap or a drain
    task automatic send_sample(input logic [31:0] ref_w, input logic [31:0] fb_w);
        int gap;
        gap = draw_tx_gap();
        if (gap > 0)
        begin
            speed_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        speed_in.valid          <= 1'b1;
        speed_in.speed_ref_hz   <= ref_w;
        speed_in.speed_feedback <= fb_w;
        do
            @(posedge clk);
        while (!speed_in.ready);
    endtask

    task automatic drain();
        speed_in.valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
    endtask

    // mostly a held reference with feedback tracking it, plus noise and corners
    task automatic run_random(input int count);
        int          r, tgt, span;
        logic [31:0] ref_w, fb_w;
        span = 1 << $urandom_range(10, 24);
        tgt  = 0;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                if ($urandom_range(0, 15) == 0)
                    tgt = int'($urandom_range(0, 2 * span)) - span;
                ref_w = tgt;
                fb_w  = tgt * 6 + int'($urandom_range(0, 1 << 17)) - (1 << 16);
            end
            else if (r < 90)
            begin
                ref_w = $urandom;
                fb_w  = $urandom;
            end
            else
            begin
                ref_w = corner_word();
                fb_w  = corner_word();
            end
            send_sample(ref_w, fb_w);
        end
    endtask

    initial
    begin
        tracker = new();
        rst_n                   <= 1'b0;
        cfg_write               <= 1'b0;
        cfg_index               <= '0;
        cfg_data                <= '0;
        speed_in.valid          <= 1'b0;
        speed_in.speed_ref_hz   <= '0;
        speed_in.speed_feedback <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default tuning, field extremes
        program_style(0);
        send_sample(32'h0, 32'h0);
        repeat (3) send_sample(32'h000A_0000, 32'h0);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF);
        send_sample(32'hFFFF_FFFF, 32'h1);
        send_sample(32'h1, 32'hFFFF_FFFF);
        send_sample(32'h0, 32'h0);
        drain();

        // zero plant gain, widest limits
        program_regs(48'd19660800, 48'd1966080000, 48'd65536000000, 48'd0,
                     48'd163840000, 48'd6553600, 48'h0000_7FFF_FFFF, 48'h0000_8000_0000);
        send_sample(32'h000A_0000, 32'h0);
        send_sample(32'hFFF6_0000, 32'h0);
        send_sample(32'h0, 32'h7FFF_FFFF);
        send_sample(32'h0, 32'h0);
        drain();

        // crossed limits: upper -2.0, lower +2.0
        program_regs(48'd19660800, 48'd1966080000, 48'd65536000000, 48'd13107200,
                     48'd163840000, 48'd6553600, {16'd0, 32'hFFFE_0000}, 48'h2_0000);
        send_sample(32'h0064_0000, 32'h0);
        send_sample(32'hFF9C_0000, 32'h0);
        send_sample(32'h0, 32'h0);
        send_sample(32'h0064_0000, 32'h0);
        send_sample(32'hFF9C_0000, 32'h7FFF_FFFF);
        drain();

        // saturating gains, b0 of one LSB, full-range limits
        program_regs('1, '1, '1, 48'd1, 48'hFFFF_FFFF, 48'hFFFF_FFFF,
                     48'h0000_7FFF_FFFF, 48'h0000_8000_0000);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF);
        send_sample(32'h0, 32'h0);
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_sample(32'h8000_0000, 32'h8000_0000);
        send_sample(32'h1, 32'hFFFF_FFFF);
        drain();

        for (int p = 0; p < 12; p++)
        begin
            quiet = (p % 4 == 2);
            if (p == 6)
                hold_req = 1'b1;
            program_style(styles[p]);
            run_random(108);
            drain();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
src/ladrc_pkg.sv
src/ladrc_stream_if.sv
src/linear_adrc_speed_loop_core.sv
tb/tb_top.sv
